[rtl/core/sbmg_pkg.sv]
// Package for the segmented box mesh generator: widths, codes, face table.
package sbmg_pkg;

  localparam int MAX_SEGMENTS  = 64;
  localparam int FRACTION_BITS = 8;

  localparam int DIM_W   = 16;
  localparam int SEG_W   = 7;
  localparam int IDX_W   = 15;
  localparam int TEX_W   = 17;
  localparam int POS_W   = 16;
  localparam int FACE_W  = 3;
  localparam int ADDR_W  = 5;
  localparam int DATA_W  = 32;
  localparam int PROD_W  = SEG_W + DIM_W;
  localparam int COORD_W = PROD_W + 2;

  // divider: quotient bits come out one per cycle
  localparam int SEGL_W   = $clog2(MAX_SEGMENTS);
  localparam int DIVD_W   = DIM_W + SEGL_W;
  localparam int DIVCNT_W = $clog2(DIVD_W);
  localparam int QUOT_W   = 16;

  localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(1 << FRACTION_BITS);
  localparam logic [SEG_W-1:0] SEG_RESET = SEG_W'(1);
  localparam logic [SEG_W-1:0] SEG_MAX   = SEG_W'(MAX_SEGMENTS);
  localparam logic [TEX_W-1:0] TEX_ONE   = TEX_W'(1 << 16);

  // register map (word index)
  localparam logic [2:0] REG_BOX_WIDTH  = 3'd0;
  localparam logic [2:0] REG_BOX_HEIGHT = 3'd1;
  localparam logic [2:0] REG_BOX_DEPTH  = 3'd2;
  localparam logic [2:0] REG_SEG_X      = 3'd3;
  localparam logic [2:0] REG_SEG_Y      = 3'd4;
  localparam logic [2:0] REG_SEG_Z      = 3'd5;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  localparam logic [FACE_W-1:0] FACE_POS_X = 3'd0;
  localparam logic [FACE_W-1:0] FACE_NEG_X = 3'd1;
  localparam logic [FACE_W-1:0] FACE_POS_Y = 3'd2;
  localparam logic [FACE_W-1:0] FACE_NEG_Y = 3'd3;
  localparam logic [FACE_W-1:0] FACE_POS_Z = 3'd4;
  localparam logic [FACE_W-1:0] FACE_NEG_Z = 3'd5;

  localparam logic REC_VERTEX   = 1'b0;
  localparam logic REC_TRIANGLE = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_MUL,
    ST_EMIT
  } state_e;

  typedef enum logic [1:0] {
    DIV_STEP_U,
    DIV_STEP_V,
    DIV_TEX_U,
    DIV_TEX_V
  } div_op_e;

  typedef struct packed {
    logic [1:0] u;
    logic [1:0] v;
    logic [1:0] w;
    logic       u_neg;
    logic       v_neg;
    logic       w_neg;
  } face_t;

  function automatic face_t face_desc(input logic [FACE_W-1:0] f);
    face_t d;
    case (f)
      FACE_NEG_X: d = '{AXIS_Z, AXIS_Y, AXIS_X, 1'b0, 1'b1, 1'b1};
      FACE_POS_Y: d = '{AXIS_X, AXIS_Z, AXIS_Y, 1'b0, 1'b0, 1'b0};
      FACE_NEG_Y: d = '{AXIS_X, AXIS_Z, AXIS_Y, 1'b0, 1'b1, 1'b1};
      FACE_POS_Z: d = '{AXIS_X, AXIS_Y, AXIS_Z, 1'b0, 1'b1, 1'b0};
      FACE_NEG_Z: d = '{AXIS_X, AXIS_Y, AXIS_Z, 1'b1, 1'b1, 1'b1};
      default:    d = '{AXIS_Z, AXIS_Y, AXIS_X, 1'b1, 1'b1, 1'b0};
    endcase
    return d;
  endfunction

  // zero acts as one, counts above the maximum act as the maximum
  function automatic logic [SEG_W-1:0] eff_seg(input logic [SEG_W-1:0] s);
    logic [SEG_W-1:0] r;
    if (s == '0) begin
      r = SEG_W'(1);
    end else if (s > SEG_MAX) begin
      r = SEG_MAX;
    end else begin
      r = s;
    end
    return r;
  endfunction

endpackage

[rtl/core/segmented_box_mesh_generator.sv]
// Segmented box mesh generator: sequencer, shared divider/multiplier, config port.

// Each input transfer yields one record of a box whose six faces are cut into
// grids: first the grid vertices of a face (position Q8.8, uv Q1.16), then two
// triangles per cell, face after face, wrapping after the last triangle of -z.
// restart = 1 jumps back to the first vertex of +x. For a vertex record a
// bit-serial restoring divider computes four quotients (two grid steps, two
// texture coordinates) at one quotient bit per cycle, then one shared 7x16
// multiplier runs twice. A triangle record skips the divider and takes two
// multiplier passes. A finished record sits in the output register, so the
// next input transfer can be taken while it waits. Write configuration only
// while no record is in work.
module segmented_box_mesh_generator (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // config port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [sbmg_pkg::ADDR_W-1:0]     paddr,
  input  logic [sbmg_pkg::DATA_W-1:0]     pwdata,
  output logic [sbmg_pkg::DATA_W-1:0]     prdata,
  output logic                            pready,
  // input channel
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            restart_i,
  // output channel
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic                            record_kind_o,
  output logic [sbmg_pkg::FACE_W-1:0]     face_number_o,
  output logic signed [sbmg_pkg::POS_W-1:0] pos_x_o,
  output logic signed [sbmg_pkg::POS_W-1:0] pos_y_o,
  output logic signed [sbmg_pkg::POS_W-1:0] pos_z_o,
  output logic [sbmg_pkg::TEX_W-1:0]      tex_u_o,
  output logic [sbmg_pkg::TEX_W-1:0]      tex_v_o,
  output logic [sbmg_pkg::IDX_W-1:0]      corner_a_o,
  output logic [sbmg_pkg::IDX_W-1:0]      corner_b_o,
  output logic [sbmg_pkg::IDX_W-1:0]      corner_c_o,
  output logic                            last_record_o
);
  import sbmg_pkg::*;

  // config registers
  logic [DIM_W-1:0] dim_q [3];
  logic [SEG_W-1:0] seg_q [3];

  // sequence state
  state_e            state_q, state_d;
  logic [FACE_W-1:0] face_q, face_d;
  logic              tri_q, tri_d;
  logic [SEG_W-1:0]  col_q, col_d;
  logic [SEG_W-1:0]  row_q, row_d;
  logic              second_q, second_d;
  logic [IDX_W-1:0]  base_q, base_d;
  logic [DIM_W-1:0]  step_u_q, step_u_d;
  logic [DIM_W-1:0]  step_v_q, step_v_d;

  // shared divider
  div_op_e             op_q, op_d;
  logic [DIVCNT_W-1:0] bit_q, bit_d;
  logic [SEG_W-1:0]    rem_q, rem_d;
  logic [QUOT_W-1:0]   quot_q, quot_d;
  logic [QUOT_W-1:0]   tex_u_q, tex_u_d;
  logic [QUOT_W-1:0]   tex_v_q, tex_v_d;

  // shared multiplier
  logic              mul_sel_q, mul_sel_d;
  logic [PROD_W-1:0] prod0_q, prod0_d;
  logic [PROD_W-1:0] prod1_q, prod1_d;

  // output register
  logic                    out_valid_q, out_valid_d;
  logic                    kind_q, kind_d;
  logic [FACE_W-1:0]       ofsce_q, ofsce_d;
  logic signed [POS_W-1:0] px_q, px_d, py_q, py_d, pz_q, pz_d;
  logic [TEX_W-1:0]        tu_q, tu_d, tv_q, tv_d;
  logic [IDX_W-1:0]        ca_q, ca_d, cb_q, cb_d, cc_q, cc_d;
  logic                    last_q, last_d;

  // decode
  logic [FACE_W-1:0] face_eff;
  face_t             fd;
  logic [SEG_W-1:0]  gx, gy;
  logic [SEG_W-1:0]  g1, gy1;
  logic              in_xfer, out_free, cfg_wr;
  logic [2:0]        cfg_idx;

  // divider datapath
  logic [DIVD_W-1:0] dividend;
  logic [SEG_W-1:0]  divisor;
  logic [SEG_W:0]    rem_sh;
  logic              qbit;
  logic [QUOT_W-1:0] quot_nxt;

  // multiplier datapath
  logic [SEG_W-1:0]  mul_a;
  logic [DIM_W-1:0]  mul_b;

  // record datapath
  logic signed [COORD_W-1:0] cu, cv, cw;
  logic signed [POS_W-1:0]   pos_c [3];
  logic [IDX_W-1:0]          ia, ib;
  logic [SEG_W:0]            col_p1, row_p1;

  function automatic logic signed [POS_W-1:0] sat16(input logic signed [COORD_W-1:0] v);
    logic signed [POS_W-1:0] r;
    if (v > COORD_W'(32767)) begin
      r = 16'sh7FFF;
    end else if (v < -COORD_W'(32768)) begin
      r = 16'sh8000;
    end else begin
      r = v[POS_W-1:0];
    end
    return r;
  endfunction

  assign pready   = 1'b1;
  assign cfg_idx  = paddr[ADDR_W-1:2];
  assign cfg_wr   = psel & penable & pwrite & pready;

  always_comb begin
    case (cfg_idx)
      REG_BOX_WIDTH:  prdata = DATA_W'(dim_q[0]);
      REG_BOX_HEIGHT: prdata = DATA_W'(dim_q[1]);
      REG_BOX_DEPTH:  prdata = DATA_W'(dim_q[2]);
      REG_SEG_X:      prdata = DATA_W'(seg_q[0]);
      REG_SEG_Y:      prdata = DATA_W'(seg_q[1]);
      REG_SEG_Z:      prdata = DATA_W'(seg_q[2]);
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dim_q[0] <= DIM_RESET;
      dim_q[1] <= DIM_RESET;
      dim_q[2] <= DIM_RESET;
      seg_q[0] <= SEG_RESET;
      seg_q[1] <= SEG_RESET;
      seg_q[2] <= SEG_RESET;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_BOX_WIDTH:  dim_q[0] <= pwdata[DIM_W-1:0];
        REG_BOX_HEIGHT: dim_q[1] <= pwdata[DIM_W-1:0];
        REG_BOX_DEPTH:  dim_q[2] <= pwdata[DIM_W-1:0];
        REG_SEG_X:      seg_q[0] <= pwdata[SEG_W-1:0];
        REG_SEG_Y:      seg_q[1] <= pwdata[SEG_W-1:0];
        REG_SEG_Z:      seg_q[2] <= pwdata[SEG_W-1:0];
        default: ;
      endcase
    end
  end

  // face decode; a stray face count reads as +x
  assign face_eff = (face_q > FACE_NEG_Z) ? FACE_POS_X : face_q;
  assign fd       = face_desc(face_eff);
  assign gx       = eff_seg(seg_q[fd.u]);
  assign gy       = eff_seg(seg_q[fd.v]);
  assign g1       = gx + SEG_W'(1);
  assign gy1      = gy + SEG_W'(1);

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_xfer    = in_valid_i & ~in_stall_o;
  assign out_free   = ~out_valid_q | ~out_stall_i;

  // divider operands
  always_comb begin
    case (op_q)
      DIV_STEP_U: begin
        dividend = DIVD_W'(dim_q[fd.u]);
        divisor  = gx;
      end
      DIV_STEP_V: begin
        dividend = DIVD_W'(dim_q[fd.v]);
        divisor  = gy;
      end
      DIV_TEX_U: begin
        dividend = {col_q[SEGL_W-1:0], 16'b0};
        divisor  = gx;
      end
      default: begin
        dividend = {row_q[SEGL_W-1:0], 16'b0};
        divisor  = gy;
      end
    endcase
  end

  assign rem_sh   = {rem_q, dividend[bit_q]};
  assign qbit     = (rem_sh >= {1'b0, divisor});
  assign quot_nxt = {quot_q[QUOT_W-2:0], qbit};

  // multiplier operands: vertex uses the grid steps, triangle the row pitch
  always_comb begin
    if (tri_q) begin
      mul_a = mul_sel_q ? gy1 : row_q;
      mul_b = DIM_W'(g1);
    end else begin
      mul_a = mul_sel_q ? row_q : col_q;
      mul_b = mul_sel_q ? step_v_q : step_u_q;
    end
  end

  // record values
  always_comb begin
    cu = $signed({2'b0, prod0_q}) - $signed(COORD_W'(dim_q[fd.u][DIM_W-1:1]));
    cv = $signed({2'b0, prod1_q}) - $signed(COORD_W'(dim_q[fd.v][DIM_W-1:1]));
    cw = $signed(COORD_W'(dim_q[fd.w][DIM_W-1:1]));
    if (fd.u_neg) cu = -cu;
    if (fd.v_neg) cv = -cv;
    if (fd.w_neg) cw = -cw;
    pos_c[0] = '0;
    pos_c[1] = '0;
    pos_c[2] = '0;
    pos_c[fd.u] = sat16(cu);
    pos_c[fd.v] = sat16(cv);
    pos_c[fd.w] = sat16(cw);
  end

  assign ia     = base_q + IDX_W'(col_q) + prod0_q[IDX_W-1:0];
  assign ib     = ia + IDX_W'(g1);
  assign col_p1 = {1'b0, col_q} + (SEG_W+1)'(1);
  assign row_p1 = {1'b0, row_q} + (SEG_W+1)'(1);

  always_comb begin
    state_d     = state_q;
    face_d      = face_q;
    tri_d       = tri_q;
    col_d       = col_q;
    row_d       = row_q;
    second_d    = second_q;
    base_d      = base_q;
    step_u_d    = step_u_q;
    step_v_d    = step_v_q;
    op_d        = op_q;
    bit_d       = bit_q;
    rem_d       = rem_q;
    quot_d      = quot_q;
    tex_u_d     = tex_u_q;
    tex_v_d     = tex_v_q;
    mul_sel_d   = mul_sel_q;
    prod0_d     = prod0_q;
    prod1_d     = prod1_q;
    out_valid_d = out_valid_q & out_stall_i;
    kind_d      = kind_q;
    ofsce_d     = ofsce_q;
    px_d        = px_q;
    py_d        = py_q;
    pz_d        = pz_q;
    tu_d        = tu_q;
    tv_d        = tv_q;
    ca_d        = ca_q;
    cb_d        = cb_q;
    cc_d        = cc_q;
    last_d      = last_q;

    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          if (restart_i) begin
            face_d   = FACE_POS_X;
            tri_d    = 1'b0;
            col_d    = '0;
            row_d    = '0;
            second_d = 1'b0;
            base_d   = '0;
            step_u_d = '0;
            step_v_d = '0;
          end
          op_d      = DIV_STEP_U;
          bit_d     = DIVCNT_W'(DIVD_W - 1);
          rem_d     = '0;
          quot_d    = '0;
          mul_sel_d = 1'b0;
          state_d   = (tri_q && !restart_i) ? ST_MUL : ST_DIV;
        end
      end

      ST_DIV: begin
        rem_d  = qbit ? SEG_W'(rem_sh - {1'b0, divisor}) : rem_sh[SEG_W-1:0];
        quot_d = quot_nxt;
        bit_d  = bit_q - DIVCNT_W'(1);
        if (bit_q == '0) begin
          rem_d  = '0;
          quot_d = '0;
          bit_d  = DIVCNT_W'(DIVD_W - 1);
          case (op_q)
            DIV_STEP_U: begin
              step_u_d = quot_nxt;
              op_d     = DIV_STEP_V;
            end
            DIV_STEP_V: begin
              step_v_d = quot_nxt;
              op_d     = DIV_TEX_U;
            end
            DIV_TEX_U: begin
              tex_u_d = quot_nxt;
              op_d    = DIV_TEX_V;
            end
            default: begin
              tex_v_d = quot_nxt;
              op_d    = DIV_STEP_U;
              state_d = ST_MUL;
            end
          endcase
        end
      end

      ST_MUL: begin
        if (mul_sel_q) begin
          prod1_d = PROD_W'(mul_a) * PROD_W'(mul_b);
          state_d = ST_EMIT;
        end else begin
          prod0_d = PROD_W'(mul_a) * PROD_W'(mul_b);
        end
        mul_sel_d = ~mul_sel_q;
      end

      ST_EMIT: begin
        if (out_free) begin
          state_d     = ST_IDLE;
          out_valid_d = 1'b1;
          ofsce_d     = face_eff;
          face_d      = face_eff;
          last_d      = 1'b0;
          if (!tri_q) begin
            kind_d = REC_VERTEX;
            px_d   = pos_c[AXIS_X];
            py_d   = pos_c[AXIS_Y];
            pz_d   = pos_c[AXIS_Z];
            tu_d   = (col_q >= gx) ? TEX_ONE : TEX_W'(tex_u_q);
            tv_d   = TEX_ONE - ((row_q >= gy) ? TEX_ONE : TEX_W'(tex_v_q));
            ca_d   = '0;
            cb_d   = '0;
            cc_d   = '0;
            if (col_q >= gx) begin
              col_d = '0;
              if (row_q >= gy) begin
                row_d    = '0;
                tri_d    = 1'b1;
                second_d = 1'b0;
              end else begin
                row_d = row_q + SEG_W'(1);
              end
            end else begin
              col_d = col_q + SEG_W'(1);
            end
          end else begin
            kind_d = REC_TRIANGLE;
            px_d   = '0;
            py_d   = '0;
            pz_d   = '0;
            tu_d   = '0;
            tv_d   = '0;
            if (!second_q) begin
              ca_d     = ia;
              cb_d     = ib;
              cc_d     = ia + IDX_W'(1);
              second_d = 1'b1;
            end else begin
              ca_d     = ib;
              cb_d     = ib + IDX_W'(1);
              cc_d     = ia + IDX_W'(1);
              second_d = 1'b0;
              if (col_p1 >= {1'b0, gx}) begin
                col_d = '0;
                if (row_p1 >= {1'b0, gy}) begin
                  row_d = '0;
                  tri_d = 1'b0;
                  if (face_eff == FACE_NEG_Z) begin
                    last_d = 1'b1;
                    face_d = FACE_POS_X;
                    base_d = '0;
                  end else begin
                    base_d = base_q + prod1_q[IDX_W-1:0];
                    face_d = face_eff + FACE_W'(1);
                  end
                end else begin
                  row_d = row_q + SEG_W'(1);
                end
              end else begin
                col_d = col_q + SEG_W'(1);
              end
            end
          end
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      face_q      <= '0;
      tri_q       <= 1'b0;
      col_q       <= '0;
      row_q       <= '0;
      second_q    <= 1'b0;
      base_q      <= '0;
      step_u_q    <= '0;
      step_v_q    <= '0;
      op_q        <= DIV_STEP_U;
      bit_q       <= '0;
      mul_sel_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      face_q      <= face_d;
      tri_q       <= tri_d;
      col_q       <= col_d;
      row_q       <= row_d;
      second_q    <= second_d;
      base_q      <= base_d;
      step_u_q    <= step_u_d;
      step_v_q    <= step_v_d;
      op_q        <= op_d;
      bit_q       <= bit_d;
      mul_sel_q   <= mul_sel_d;
      out_valid_q <= out_valid_d;
    end
  end

  // datapath and payload registers
  always_ff @(posedge clk_i) begin
    rem_q   <= rem_d;
    quot_q  <= quot_d;
    tex_u_q <= tex_u_d;
    tex_v_q <= tex_v_d;
    prod0_q <= prod0_d;
    prod1_q <= prod1_d;
    kind_q  <= kind_d;
    ofsce_q <= ofsce_d;
    px_q    <= px_d;
    py_q    <= py_d;
    pz_q    <= pz_d;
    tu_q    <= tu_d;
    tv_q    <= tv_d;
    ca_q    <= ca_d;
    cb_q    <= cb_d;
    cc_q    <= cc_d;
    last_q  <= last_d;
  end

  assign out_valid_o   = out_valid_q;
  assign record_kind_o = kind_q;
  assign face_number_o = ofsce_q;
  assign pos_x_o       = px_q;
  assign pos_y_o       = py_q;
  assign pos_z_o       = pz_q;
  assign tex_u_o       = tu_q;
  assign tex_v_o       = tv_q;
  assign corner_a_o    = ca_q;
  assign corner_b_o    = cb_q;
  assign corner_c_o    = cc_q;
  assign last_record_o = last_q;

endmodule

[dv/segmented_box_mesh_generator_tb.sv]
// Self-checking testbench for the segmented box mesh generator: predicted records vs. output.
module segmented_box_mesh_generator_tb;
  import sbmg_pkg::*;

  localparam int ITEM_TARGET = 1750;
  localparam int HOLD_CYCLES = 800;
  localparam int SETTLE_CYCLES = 120;
  localparam longint CYCLE_LIMIT = 3_000_000;

  typedef struct packed {
    logic               kind;
    logic [FACE_W-1:0]  face;
    logic [POS_W-1:0]   px;
    logic [POS_W-1:0]   py;
    logic [POS_W-1:0]   pz;
    logic [TEX_W-1:0]   tu;
    logic [TEX_W-1:0]   tv;
    logic [IDX_W-1:0]   ca;
    logic [IDX_W-1:0]   cb;
    logic [IDX_W-1:0]   cc;
    logic               last;
  } mesh_record_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  logic in_valid = 1'b0;
  logic restart_bit = 1'b0;
  logic in_stall_o;
  logic out_valid_o;
  logic out_stall = 1'b0;

  logic               record_kind_o;
  logic [FACE_W-1:0]  face_number_o;
  logic signed [POS_W-1:0] pos_x_o, pos_y_o, pos_z_o;
  logic [TEX_W-1:0]   tex_u_o, tex_v_o;
  logic [IDX_W-1:0]   corner_a_o, corner_b_o, corner_c_o;
  logic               last_record_o;

  // predictor copy of the registers and the sequencer state
  logic [DIM_W-1:0] box_size [3];
  logic [SEG_W-1:0] seg_count [3];
  logic [FACE_W-1:0] face_cnt;
  logic              in_triangles;
  logic [SEG_W-1:0]  col_cnt;
  logic [SEG_W-1:0]  row_cnt;
  logic              second_tri;
  logic [IDX_W-1:0]  base_idx;

  bit           restart_items [$];
  mesh_record_t expected_records [$];
  mesh_record_t want;

  int     send_idle_pct = 0;
  int     recv_stall_pct = 0;
  int     hold_requests = 0;
  int     holds_served = 0;
  int     hold_left = 0;
  int     failures = 0;
  int     items_queued = 0;
  longint cycle_count = 0;

  segmented_box_mesh_generator u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall_o),
    .restart_i     (restart_bit),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall),
    .record_kind_o (record_kind_o),
    .face_number_o (face_number_o),
    .pos_x_o       (pos_x_o),
    .pos_y_o       (pos_y_o),
    .pos_z_o       (pos_z_o),
    .tex_u_o       (tex_u_o),
    .tex_v_o       (tex_v_o),
    .corner_a_o    (corner_a_o),
    .corner_b_o    (corner_b_o),
    .corner_c_o    (corner_c_o),
    .last_record_o (last_record_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // in-plane axes u/v, normal axis w and their direction signs per face
  function automatic void face_axes(input logic [FACE_W-1:0] f, output int u, output int v,
                                    output int w, output int su, output int sv, output int sw);
    case (f)
      FACE_NEG_X: begin u = AXIS_Z; v = AXIS_Y; w = AXIS_X; su =  1; sv = -1; sw = -1; end
      FACE_POS_Y: begin u = AXIS_X; v = AXIS_Z; w = AXIS_Y; su =  1; sv =  1; sw =  1; end
      FACE_NEG_Y: begin u = AXIS_X; v = AXIS_Z; w = AXIS_Y; su =  1; sv = -1; sw = -1; end
      FACE_POS_Z: begin u = AXIS_X; v = AXIS_Y; w = AXIS_Z; su =  1; sv = -1; sw =  1; end
      FACE_NEG_Z: begin u = AXIS_X; v = AXIS_Y; w = AXIS_Z; su = -1; sv = -1; sw = -1; end
      default:    begin u = AXIS_Z; v = AXIS_Y; w = AXIS_X; su = -1; sv = -1; sw =  1; end
    endcase
  endfunction

  function automatic longint seg_limit(input logic [SEG_W-1:0] s);
    longint n;
    n = s;
    if (n < 1) n = 1;
    if (n > MAX_SEGMENTS) n = MAX_SEGMENTS;
    return n;
  endfunction

  function automatic logic [POS_W-1:0] clamp_pos(input longint p);
    if (p > 32767) p = 32767;
    if (p < -32768) p = -32768;
    return POS_W'(p);
  endfunction

  // advances the sequencer by one transfer and returns the record it yields
  function automatic mesh_record_t next_record(input logic restart);
    int u, v, w, su, sv, sw;
    longint gx, gy, step_u, step_v, col, row, frac, g1, ia, ib, base;
    longint pos [3];
    mesh_record_t r;
    if (restart) begin
      face_cnt = FACE_POS_X;
      in_triangles = 1'b0;
      col_cnt = '0;
      row_cnt = '0;
      second_tri = 1'b0;
      base_idx = '0;
    end
    if (face_cnt > FACE_NEG_Z) face_cnt = FACE_POS_X;
    face_axes(face_cnt, u, v, w, su, sv, sw);
    gx = seg_limit(seg_count[u]);
    gy = seg_limit(seg_count[v]);
    step_u = longint'(box_size[u]) / gx;
    step_v = longint'(box_size[v]) / gy;
    col = col_cnt;
    row = row_cnt;
    base = base_idx;
    r = '0;
    r.face = face_cnt;
    if (!in_triangles) begin
      r.kind = REC_VERTEX;
      pos[u] = (col * step_u - longint'(box_size[u] >> 1)) * su;
      pos[v] = (row * step_v - longint'(box_size[v] >> 1)) * sv;
      pos[w] = longint'(box_size[w] >> 1) * sw;
      r.px = clamp_pos(pos[0]);
      r.py = clamp_pos(pos[1]);
      r.pz = clamp_pos(pos[2]);
      r.tu = (col >= gx) ? TEX_W'(65536) : TEX_W'((col * 65536) / gx);
      frac = (row >= gy) ? 65536 : (row * 65536) / gy;
      r.tv = TEX_W'(65536 - frac);
      if (col >= gx) begin
        col_cnt = '0;
        if (row >= gy) begin
          row_cnt = '0;
          in_triangles = 1'b1;
          second_tri = 1'b0;
        end else begin
          row_cnt = SEG_W'(row + 1);
        end
      end else begin
        col_cnt = SEG_W'(col + 1);
      end
    end else begin
      r.kind = REC_TRIANGLE;
      g1 = gx + 1;
      ia = base + col + g1 * row;
      ib = base + col + g1 * (row + 1);
      if (!second_tri) begin
        r.ca = IDX_W'(ia);
        r.cb = IDX_W'(ib);
        r.cc = IDX_W'(ia + 1);
        second_tri = 1'b1;
      end else begin
        r.ca = IDX_W'(ib);
        r.cb = IDX_W'(ib + 1);
        r.cc = IDX_W'(ia + 1);
        second_tri = 1'b0;
        if (col + 1 >= gx) begin
          col_cnt = '0;
          if (row + 1 >= gy) begin
            row_cnt = '0;
            in_triangles = 1'b0;
            if (face_cnt == FACE_NEG_Z) begin
              r.last = 1'b1;
              face_cnt = FACE_POS_X;
              base_idx = '0;
            end else begin
              base_idx = IDX_W'(base + g1 * (gy + 1));
              face_cnt = face_cnt + 1'b1;
            end
          end else begin
            row_cnt = SEG_W'(row + 1);
          end
        end else begin
          col_cnt = SEG_W'(col + 1);
        end
      end
    end
    return r;
  endfunction

  task automatic check_field(input string field, input longint exp_val, input longint act_val);
    if (exp_val != act_val) begin
      $error("%s: expected %0d, actual %0d", field, exp_val, act_val);
      failures++;
    end
  endtask

  // sender: one transfer per accepted item, prediction made at acceptance
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      restart_bit <= 1'b0;
    end else begin
      if (in_valid && !in_stall_o) begin
        expected_records = {expected_records, next_record(restart_bit)};
      end
      if (!in_valid || !in_stall_o) begin
        if (restart_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          restart_bit <= restart_items.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver stall, with an occasional long hold-off to back the block up
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
      hold_left <= 0;
      holds_served <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (holds_served != hold_requests) begin
      holds_served <= holds_served + 1;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall) begin
      if (expected_records.size() == 0) begin
        $error("record transfer with nothing expected (kind %0d, face %0d)",
               record_kind_o, face_number_o);
        failures++;
      end else begin
        want = expected_records.pop_front();
        check_field("record_kind", want.kind, record_kind_o);
        check_field("face_number", want.face, face_number_o);
        check_field("pos_x", $signed(want.px), pos_x_o);
        check_field("pos_y", $signed(want.py), pos_y_o);
        check_field("pos_z", $signed(want.pz), pos_z_o);
        check_field("tex_u", want.tu, tex_u_o);
        check_field("tex_v", want.tv, tex_v_o);
        check_field("corner_a", want.ca, corner_a_o);
        check_field("corner_b", want.cb, corner_b_o);
        check_field("corner_c", want.cc, corner_c_o);
        check_field("last_record", want.last, last_record_o);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic write_register(input logic [2:0] idx, input logic [DATA_W-1:0] value);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_W'({idx, 2'b00});
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx <= REG_BOX_DEPTH) begin
      box_size[idx] = value[DIM_W-1:0];
    end else begin
      seg_count[idx - REG_SEG_X] = value[SEG_W-1:0];
    end
  endtask

  task automatic set_mesh(input int w, input int h, input int d,
                          input int sx, input int sy, input int sz);
    write_register(REG_BOX_WIDTH, DATA_W'(w));
    write_register(REG_BOX_HEIGHT, DATA_W'(h));
    write_register(REG_BOX_DEPTH, DATA_W'(d));
    write_register(REG_SEG_X, DATA_W'(sx));
    write_register(REG_SEG_Y, DATA_W'(sy));
    write_register(REG_SEG_Z, DATA_W'(sz));
  endtask

  task automatic set_idling(input int send_pct, input int recv_pct);
    @(posedge clk_i);
    send_idle_pct <= send_pct;
    recv_stall_pct <= recv_pct;
  endtask

  // all items taken, all records out, then a margin so the block is idle;
  // checked between edges so the driver's updates have landed
  task automatic wait_drained();
    while (restart_items.size() != 0 || in_valid) @(negedge clk_i);
    while (expected_records.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic run_items(input int count, input int restart_pct, input bit restart_first);
    for (int i = 0; i < count; i++) begin
      restart_items = {restart_items,
                       bit'((i == 0 && restart_first) || ($urandom_range(99) < restart_pct))};
    end
    items_queued += count;
    wait_drained();
  endtask

  function automatic int pick_dim();
    int r;
    r = $urandom_range(5);
    case (r)
      0: return 0;
      1: return 65535;
      2: return $urandom_range(0, 65535);
      default: return $urandom_range(128, 2048);
    endcase
  endfunction

  function automatic int pick_seg();
    int r;
    r = $urandom_range(11);
    case (r)
      0: return 0;
      1: return MAX_SEGMENTS;
      2: return $urandom_range(0, MAX_SEGMENTS);
      default: return $urandom_range(1, 3);
    endcase
  endfunction

  initial begin
    int phase;
    int mode;
    box_size = '{DIM_W'(256), DIM_W'(256), DIM_W'(256)};
    seg_count = '{SEG_W'(1), SEG_W'(1), SEG_W'(1)};
    face_cnt = FACE_POS_X;
    in_triangles = 1'b0;
    col_cnt = '0;
    row_cnt = '0;
    second_tri = 1'b0;
    base_idx = '0;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // reset grid: first face through its triangles, a restart in the middle
    restart_items = '{1, 0, 0, 0, 0, 0, 0, 0, 1, 0};
    items_queued += 10;
    wait_drained();

    // extreme sizes written mid-mesh: saturating positions, zero height,
    // zero and maximum segment counts
    set_mesh(65535, 0, 65535, MAX_SEGMENTS, 2, 0);
    run_items(12, 0, 1'b0);

    phase = 0;
    while (items_queued < ITEM_TARGET) begin
      mode = phase % 4;
      case (mode)
        0: set_idling(0, 0);
        1: set_idling(51, 0);
        2: set_idling(0, 51);
        default: set_idling(30, 30);
      endcase
      if (phase == 1) begin
        // widest grid along x: runs through 64-column triangle rows
        set_mesh(pick_dim(), pick_dim(), pick_dim(), MAX_SEGMENTS, 0, 0);
        run_items(320, 0, 1'b1);
      end else if (phase == 2) begin
        set_mesh(pick_dim(), pick_dim(), pick_dim(), 1, 1, 1);
        set_idling(0, 0);
        @(posedge clk_i);
        hold_requests <= hold_requests + 1;
        run_items(150, 1, 1'b0);
      end else begin
        set_mesh(pick_dim(), pick_dim(), pick_dim(), pick_seg(), pick_seg(), pick_seg());
        // every sixth phase is restart-heavy noise
        run_items($urandom_range(60, 200), (phase % 6 == 5) ? 25 : 2, 1'b0);
      end
      phase++;
    end

    wait_drained();
    if (failures == 0 && expected_records.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
